FILE: design/rse_pkg.sv
// Shared types, codes and constants of the resizing stack engine.
`default_nettype none

package rse_pkg;

    // Default sizing
    localparam int DEPTH_DEF      = 4096;
    localparam int DATA_WIDTH_DEF = 32;

    // Fixed field widths
    localparam int FUNC_W    = 2;
    localparam int VALUE_W   = 32;
    localparam int REG_W     = 13;
    localparam int STATUS_W  = 2;
    localparam int TOTAL_W   = 32;
    localparam int CFG_IDX_W = 2;

    // Operation codes
    localparam logic [FUNC_W-1:0] FUNC_PUSH = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_POP  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_PEEK = 2'd2;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_POP_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 2'd2;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_INIT_CAP     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SHRINK_FLOOR = 2'd1;

    // Reset values of the registers
    localparam int INIT_CAP_RESET = 10;
    localparam int FLOOR_RESET    = 10;

    // Shrink test: 20*count <= 3*cap + 20
    localparam int SHRINK_BIAS = 20;

    // Top value reported on an empty stack (-99)
    localparam logic [VALUE_W-1:0] EMPTY_MARK = 32'hFFFF_FF9D;

    typedef enum logic {
        S_IDLE,
        S_POP_READ
    } t_state;

endpackage

`default_nettype wire

FILE: design/rse_intf.sv
// Channel interfaces: operation input, result output and register write.
`default_nettype none

interface rse_op_if import rse_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic [FUNC_W-1:0]         func;
    logic signed [VALUE_W-1:0] push_value;

    modport source (output valid, output func, output push_value, input ready);
    modport sink   (input valid, input func, input push_value, output ready);
endinterface

interface rse_res_if import rse_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic signed [VALUE_W-1:0] top_value;
    logic                      is_empty;
    logic [REG_W-1:0]          occupancy;
    logic [REG_W-1:0]          capacity_now;
    logic [TOTAL_W-1:0]        resize_total;
    logic [STATUS_W-1:0]       status;

    modport source (output valid, output top_value, output is_empty, output occupancy,
                    output capacity_now, output resize_total, output status,
                    input ready);
    modport sink   (input valid, input top_value, input is_empty, input occupancy,
                    input capacity_now, input resize_total, input status,
                    output ready);
endinterface

interface rse_cfg_if import rse_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [REG_W-1:0]     data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

FILE: design/resizing_stack_engine.sv
// Stack in one synchronous memory with a logical capacity that doubles and halves.
// Timing: push, peek and a pop that empties the stack register their result in the cycle
//   after the input transfer; a pop that leaves entries reads the memory in S_POP_READ first.
// Throughput: one push or peek per cycle while the result output is not stalled; a pop that
//   leaves entries holds the input in S_POP_READ while the single read port fetches the top.
// Reset (i_rst_n low, synchronous): count and resize counter cleared, capacity and
//   shrink floor loaded with 10; the entry memory is not cleared and needs no pass.
`default_nettype none

module resizing_stack_engine import rse_pkg::*; #(
    parameter int DEPTH      = DEPTH_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    rse_op_if.sink    i_op,
    rse_res_if.source o_res,
    rse_cfg_if.sink   i_cfg
);

    localparam int AW   = $clog2(DEPTH);
    localparam int CW   = $clog2(DEPTH + 1);      // holds 0..DEPTH
    localparam int CMPW = (CW > REG_W) ? CW : REG_W;
    localparam int MW   = CW + 5;                 // room for 20*count

    localparam logic [CW-1:0]   DEPTH_C   = CW'(DEPTH);
    localparam logic [CW:0]     DEPTH_X   = (CW + 1)'(DEPTH);
    localparam logic [CW-1:0]   CAP_RST   = CW'(INIT_CAP_RESET);
    localparam logic [CMPW-1:0] DEPTH_CMP = CMPW'(DEPTH);
    localparam logic [MW-1:0]   BIAS_M    = MW'(SHRINK_BIAS);

    // Stored value to the 32 bit result field: zero-extend or truncate
    function automatic logic [VALUE_W-1:0] to_out(input logic [DATA_WIDTH-1:0] v);
        logic [63:0] t;
        t = 64'(v);
        return t[VALUE_W-1:0];
    endfunction

    // ------------------------------------------------------------------
    // State
    // ------------------------------------------------------------------
    t_state                r_state, n_state;
    logic [CW-1:0]         r_count, n_count;
    logic [CW-1:0]         r_cap, n_cap;
    logic [TOTAL_W-1:0]    r_resize, n_resize;
    logic [REG_W-1:0]      r_floor, n_floor;
    logic [DATA_WIDTH-1:0] r_top, n_top;            // cached top entry

    logic [DATA_WIDTH-1:0] r_mem [DEPTH];
    logic [DATA_WIDTH-1:0] r_rd_data;

    // Result register
    logic                  r_out_valid;
    logic [VALUE_W-1:0]    r_out_top;
    logic                  r_out_empty;
    logic [REG_W-1:0]      r_out_occ;
    logic [REG_W-1:0]      r_out_cap;
    logic [TOTAL_W-1:0]    r_out_rsz;
    logic [STATUS_W-1:0]   r_out_status;

    // ------------------------------------------------------------------
    // Handshakes
    // ------------------------------------------------------------------
    logic in_ready, rd_en;
    logic op_fire, cfg_fire;
    logic pop_reads;

    assign op_fire  = i_op.valid && in_ready;
    assign cfg_fire = i_cfg.valid && i_cfg.ready;
    assign i_op.ready  = in_ready;
    assign i_cfg.ready = 1'b1;

    // A pop that leaves at least one entry must fetch the entry below the top
    assign pop_reads = (i_op.func == FUNC_POP) && (r_count >= CW'(2));

    // ------------------------------------------------------------------
    // Resize check, evaluated on the count the operation sees
    // ------------------------------------------------------------------
    logic [CW-1:0] cnt_pop, chk_cnt, rs_cap, rd_idx;
    logic [CW:0]   cap2x;
    logic [MW-1:0] lhs, rhs;
    logic          grow_want, grow_ok, shrink_want, rs_inc, refuse;

    assign cnt_pop = (r_count == '0) ? '0 : r_count - CW'(1);
    assign chk_cnt = (i_op.func == FUNC_PUSH) ? r_count : cnt_pop;
    assign rd_idx  = r_count - CW'(2);

    always_comb begin
        cap2x       = {r_cap, 1'b0};
        grow_want   = chk_cnt >= r_cap;
        grow_ok     = cap2x <= DEPTH_X;
        // 20*count <= 3*cap + 20, by shifts
        lhs         = (MW'(chk_cnt) << 4) + (MW'(chk_cnt) << 2);
        rhs         = (MW'(r_cap) << 1) + MW'(r_cap) + BIAS_M;
        shrink_want = (CMPW'(r_cap) > CMPW'(r_floor)) && (r_cap >= CW'(2)) && (lhs <= rhs);
        if (grow_want) begin
            rs_cap = grow_ok ? cap2x[CW-1:0] : r_cap;
            rs_inc = grow_ok;
        end else if (shrink_want) begin
            rs_cap = r_cap >> 1;
            rs_inc = 1'b1;
        end else begin
            rs_cap = r_cap;
            rs_inc = 1'b0;
        end
        refuse = (r_count >= DEPTH_C) || (grow_want && !grow_ok);
    end

    // Clamped capacity for a write of initial_capacity
    logic [CW-1:0] cfg_cap;
    always_comb begin
        if (i_cfg.data == '0) begin
            cfg_cap = CW'(1);
        end else if (CMPW'(i_cfg.data) > DEPTH_CMP) begin
            cfg_cap = DEPTH_C;
        end else begin
            cfg_cap = CW'(i_cfg.data);
        end
    end

    // ------------------------------------------------------------------
    // Next-value logic
    // ------------------------------------------------------------------
    logic                  wr_en;
    logic [DATA_WIDTH-1:0] push_dw;
    logic [STATUS_W-1:0]   n_status;
    logic [VALUE_W-1:0]    n_out_top;

    assign push_dw = DATA_WIDTH'($unsigned(i_op.push_value));

    always_comb begin
        n_count  = r_count;
        n_cap    = r_cap;
        n_resize = r_resize;
        n_floor  = r_floor;
        n_top    = r_top;
        n_status = ST_OK;
        wr_en    = 1'b0;
        if (op_fire) begin
            unique case (i_op.func)
                FUNC_PUSH: begin
                    if (refuse) begin
                        n_status = ST_OVERFLOW;
                    end else begin
                        n_cap    = rs_cap;
                        n_resize = r_resize + TOTAL_W'(rs_inc);
                        n_count  = r_count + CW'(1);
                        n_top    = push_dw;
                        wr_en    = 1'b1;
                    end
                end
                FUNC_POP: begin
                    if (r_count == '0) begin
                        n_status = ST_POP_EMPTY;
                    end
                    n_count  = cnt_pop;
                    n_cap    = rs_cap;
                    n_resize = r_resize + TOTAL_W'(rs_inc);
                end
                default: ;  // peek and unused code: report only
            endcase
        end
        if (r_state == S_POP_READ) begin
            n_top = r_rd_data;
        end
        // register writes are to arrive only while idle; the block itself does not enforce it
        if (cfg_fire && i_cfg.index == REG_INIT_CAP) begin
            n_cap = cfg_cap;
        end
        if (cfg_fire && i_cfg.index == REG_SHRINK_FLOOR) begin
            n_floor = i_cfg.data;
        end
        n_out_top = (n_count == '0) ? EMPTY_MARK : to_out(n_top);
    end

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:     if (op_fire && pop_reads) n_state = S_POP_READ;
            S_POP_READ: n_state = S_IDLE;
            default:    n_state = S_IDLE;
        endcase
    end

    always_comb begin
        in_ready = 1'b0;
        rd_en    = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                in_ready = !r_out_valid || o_res.ready;
                rd_en    = op_fire && pop_reads;
            end
            S_POP_READ: ;
            default: ;
        endcase
    end

    // ------------------------------------------------------------------
    // Memory: one write port, one registered read port
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_count[AW-1:0]] <= push_dw;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_data <= r_mem[rd_idx[AW-1:0]];
        end
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_cap    <= CAP_RST;
            r_resize <= '0;
            r_floor  <= REG_W'(FLOOR_RESET);
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_cap    <= n_cap;
            r_resize <= n_resize;
            r_floor  <= n_floor;
        end
    end

    always_ff @(posedge i_clk) begin
        r_top <= n_top;
    end

    // Result register: fields load at the transfer, the top value again
    // after the pop read returns
    logic load_out;
    assign load_out = (op_fire && !pop_reads) || (r_state == S_POP_READ);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (op_fire) begin
            r_out_empty  <= n_count == '0;
            r_out_occ    <= REG_W'(n_count);
            r_out_cap    <= REG_W'(n_cap);
            r_out_rsz    <= n_resize;
            r_out_status <= n_status;
        end
        if (op_fire || r_state == S_POP_READ) begin
            r_out_top <= n_out_top;
        end
    end

    assign o_res.valid        = r_out_valid;
    assign o_res.top_value    = r_out_top;
    assign o_res.is_empty     = r_out_empty;
    assign o_res.occupancy    = r_out_occ;
    assign o_res.capacity_now = r_out_cap;
    assign o_res.resize_total = r_out_rsz;
    assign o_res.status       = r_out_status;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= DEPTH_C)
        else $error("entry count above depth");

    a_cap_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cap != '0) && (r_cap <= DEPTH_C))
        else $error("capacity out of range");

    a_resize_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_resize != $past(r_resize)) |-> (r_resize == $past(r_resize) + TOTAL_W'(1)))
        else $error("resize counter moved by more than one");

    a_pop_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_POP_READ) |-> (!r_out_valid && !in_ready))
        else $error("result busy during pop read");

    a_pop_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_POP_READ) |=> (r_state == S_IDLE && r_out_valid && !r_out_empty))
        else $error("pop read did not produce a result");

endmodule

`default_nettype wire
